>>> rtl/radix_digit_emitter_top_defines.svh
// ----------------------------------------------------------------------------
// Radix digit emitter assertion macros
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH
`define RADIX_DIGIT_EMITTER_TOP_DEFINES_SVH

// Same-cycle implication.
`define RDE_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RDE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// Radix digit emitter package
// Types, register indexes and constants shared by the emitter modules.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int VALUE_W       = 64;
  localparam int RADIX_W       = 5;
  localparam int DIGIT_W       = 4;
  localparam int CHAR_W        = 8;
  localparam int DIGIT_TOTAL_W = 7;
  localparam int CFG_INDEX_W   = 2;
  localparam int CHUNK_W       = 8;
  localparam int STEP_W        = 3;

  localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;
  localparam logic [RADIX_W-1:0] MAX_RADIX = 5'd16;

  localparam logic [RADIX_W-1:0] RADIX_RESET     = 5'd10;
  localparam logic [VALUE_W-1:0] ALPHA_LOW_RESET = 64'h3736353433323130;
  localparam logic [VALUE_W-1:0] ALPHA_HIGH_RESET = 64'h6665646362613938;

  localparam logic [CFG_INDEX_W-1:0] REG_RADIX      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LOW  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_HIGH = 2'd2;

  typedef struct packed {
    logic                     valid;
    logic [DIGIT_TOTAL_W-1:0] count;
  } job_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    e = r;
    if (e < MIN_RADIX) begin
      e = MIN_RADIX;
    end
    if (e > MAX_RADIX) begin
      e = MAX_RADIX;
    end
    return e;
  endfunction

endpackage

>>> rtl/rde_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/rde_front.sv
// ----------------------------------------------------------------------------
// Radix digit emitter front end
// Accepts a value and splits it into digits with an eight-bit-per-cycle
// restoring divider, writing digits into the free bank of the digit store.
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_top_defines.svh"

module rde_front #(
  parameter int IDXW = 6,
  parameter int MAX_DIGITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rde_pkg::VALUE_W-1:0]   value,
  input  logic [rde_pkg::RADIX_W-1:0]   radix,
  input  logic                          q_full,
  output rde_pkg::job_t                 job,
  output logic                          wr_en,
  output logic [IDXW-1:0]               wr_idx,
  output logic [rde_pkg::DIGIT_W-1:0]   wr_data
);

  import rde_pkg::*;

  typedef enum logic {F_IDLE, F_DIV} fstate_t;

  fstate_t              state;
  logic [VALUE_W-1:0]   work;
  logic [DIGIT_W-1:0]   rem;
  logic [STEP_W-1:0]    step;
  logic [IDXW-1:0]      cnt;
  logic [RADIX_W-1:0]   r_eff;

  logic [DIGIT_W:0]     rem_v;
  logic [DIGIT_W:0]     trial;
  logic [CHUNK_W-1:0]   qbits;
  logic [VALUE_W-1:0]   work_next;
  logic                 last_step;
  logic                 done;

  always_comb begin
    rem_v = {1'b0, rem};
    trial = '0;
    qbits = '0;
    for (int i = CHUNK_W - 1; i >= 0; i--) begin
      trial = {rem_v[DIGIT_W-1:0], work[VALUE_W-CHUNK_W+i]};
      if (trial >= r_eff) begin
        trial = trial - r_eff;
        qbits[i] = 1'b1;
      end
      rem_v = trial;
    end
    work_next = {work[VALUE_W-CHUNK_W-1:0], qbits};
  end

  assign last_step = (state == F_DIV) && (step == '1);
  assign done = (work_next == '0) || (cnt == IDXW'(MAX_DIGITS - 1));

  assign in_ready  = (state == F_IDLE) && !q_full;
  assign wr_en     = last_step;
  assign wr_idx    = cnt;
  assign wr_data   = rem_v[DIGIT_W-1:0];
  assign job.valid = last_step && done;
  assign job.count = DIGIT_TOTAL_W'(cnt) + DIGIT_TOTAL_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid && in_ready) begin
            work  <= value;
            rem   <= '0;
            step  <= '0;
            cnt   <= '0;
            r_eff <= eff_radix(radix);
            state <= F_DIV;
          end
        end
        F_DIV: begin
          work <= work_next;
          step <= step + STEP_W'(1);
          if (last_step) begin
            rem <= '0;
            cnt <= cnt + IDXW'(1);
            if (done) begin
              state <= F_IDLE;
            end
          end else begin
            rem <= rem_v[DIGIT_W-1:0];
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

  `RDE_ASSERT_IMPL(a_digit_below_radix, wr_en, {1'b0, wr_data} < r_eff, "digit not below radix")
  `RDE_ASSERT_IMPL(a_radix_in_range, state == F_DIV, (r_eff >= MIN_RADIX) && (r_eff <= MAX_RADIX), "radix out of range")

endmodule

>>> rtl/rde_queue.sv
// ----------------------------------------------------------------------------
// Radix digit emitter job queue
// Two-entry queue of digit counts; its pointers select the digit store bank
// that the front end fills and the back end drains.
// ----------------------------------------------------------------------------
`include "radix_digit_emitter_top_defines.svh"

module rde_queue (
  input  logic          clk,
  input  logic          rst,
  input  rde_pkg::job_t push_job,
  input  logic          pop,
  output rde_pkg::job_t head,
  output logic          full,
  output logic          wr_bank,
  output logic          rd_bank
);

  import rde_pkg::*;

  logic [DIGIT_TOTAL_W-1:0] entry [2];
  logic                     wr_ptr;
  logic                     rd_ptr;
  logic [1:0]               occ;

  assign full       = (occ == 2'd2);
  assign head.valid = (occ != 2'd0);
  assign head.count = entry[rd_ptr];
  assign wr_bank    = wr_ptr;
  assign rd_bank    = rd_ptr;

  always_ff @(posedge clk) begin
    if (push_job.valid) begin
      entry[wr_ptr] <= push_job.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      occ    <= 2'd0;
    end else begin
      if (push_job.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push_job.valid, pop})
        2'b10:   occ <= occ + 2'd1;
        2'b01:   occ <= occ - 2'd1;
        default: occ <= occ;
      endcase
    end
  end

  `RDE_ASSERT_IMPL(a_no_push_full, push_job.valid, !full, "push into full queue")
  `RDE_ASSERT_IMPL(a_no_pop_empty, pop, occ != 2'd0, "pop from empty queue")
  `RDE_ASSERT_NEXT(a_push_visible, push_job.valid && !pop, occ != 2'd0, "pushed job lost")

endmodule

>>> rtl/rde_back.sv
// ----------------------------------------------------------------------------
// Radix digit emitter back end
// Reads the digits of the head job most significant first, maps them
// through the alphabet and presents them on a registered output word.
// ----------------------------------------------------------------------------
module rde_back #(
  parameter int IDXW = 6
) (
  input  logic                               clk,
  input  logic                               rst,
  input  rde_pkg::job_t                      head,
  output logic                               pop,
  output logic [IDXW-1:0]                    rd_idx,
  input  logic [rde_pkg::DIGIT_W-1:0]        rd_data,
  input  logic [rde_pkg::VALUE_W-1:0]        alphabet_low,
  input  logic [rde_pkg::VALUE_W-1:0]        alphabet_high,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rde_pkg::CHAR_W-1:0]         digit_char,
  output logic [rde_pkg::DIGIT_TOTAL_W-1:0]  digit_total,
  output logic                               last
);

  import rde_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_ADDR, B_DATA, B_HOLD} bstate_t;

  bstate_t                 state;
  logic [IDXW-1:0]         pos;
  logic [2*VALUE_W-1:0]    alphabet;

  assign alphabet = {alphabet_high, alphabet_low};
  assign rd_idx   = pos;
  assign pop      = (state == B_HOLD) && out_ready && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (head.valid) begin
            pos   <= IDXW'(head.count - DIGIT_TOTAL_W'(1));
            state <= B_ADDR;
          end
        end
        B_ADDR: begin
          state <= B_DATA;
        end
        B_DATA: begin
          digit_char  <= alphabet[{rd_data, 3'b000} +: CHAR_W];
          digit_total <= head.count;
          last        <= (pos == '0);
          out_valid   <= 1'b1;
          state       <= B_HOLD;
        end
        B_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last) begin
              state <= B_IDLE;
            end else begin
              pos   <= pos - IDXW'(1);
              state <= B_ADDR;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/radix_digit_emitter_top.sv
// Throughput: the front end's divider retires eight quotient bits per cycle and takes a
// new value only once the digits of the current one are all written. The back end fetches,
// maps and presents each digit in turn and waits for out_ready before the next. Two digit
// store banks let the next value be divided while the previous one is emitted. Reset sets
// radix 10 and the alphabet "0123456789abcdef"; the digit store is not cleared.
// ----------------------------------------------------------------------------
// Radix digit emitter
// Converts an unsigned 64-bit value into alphabet characters of its digits
// in a configured radix, most significant digit first.
// ----------------------------------------------------------------------------
module radix_digit_emitter_top #(
  parameter int MAX_DIGITS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rde_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rde_pkg::VALUE_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rde_pkg::VALUE_W-1:0]        value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rde_pkg::CHAR_W-1:0]         digit_char,
  output logic [rde_pkg::DIGIT_TOTAL_W-1:0]  digit_total,
  output logic                               last
);

  import rde_pkg::*;

  localparam int IDXW      = $clog2(MAX_DIGITS);
  localparam int RAM_DEPTH = 2 * (1 << IDXW);

  logic [RADIX_W-1:0]  radix;
  logic [VALUE_W-1:0]  alphabet_low;
  logic [VALUE_W-1:0]  alphabet_high;

  job_t                push_job;
  job_t                head;
  logic                q_full;
  logic                pop;
  logic                wr_bank;
  logic                rd_bank;
  logic                wr_en;
  logic [IDXW-1:0]     wr_idx;
  logic [DIGIT_W-1:0]  wr_data;
  logic [IDXW-1:0]     rd_idx;
  logic [DIGIT_W-1:0]  rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix         <= RADIX_RESET;
      alphabet_low  <= ALPHA_LOW_RESET;
      alphabet_high <= ALPHA_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RADIX:      radix         <= cfg_data[RADIX_W-1:0];
        REG_ALPHA_LOW:  alphabet_low  <= cfg_data;
        REG_ALPHA_HIGH: alphabet_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rde_front #(
    .IDXW       (IDXW),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value    (value),
    .radix    (radix),
    .q_full   (q_full),
    .job      (push_job),
    .wr_en    (wr_en),
    .wr_idx   (wr_idx),
    .wr_data  (wr_data)
  );

  rde_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .wr_bank  (wr_bank),
    .rd_bank  (rd_bank)
  );

  rde_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (RAM_DEPTH)
  ) u_digit_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr ({wr_bank, wr_idx}),
    .wr_data (wr_data),
    .rd_addr ({rd_bank, rd_idx}),
    .rd_data (rd_data)
  );

  rde_back #(
    .IDXW (IDXW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .rd_idx        (rd_idx),
    .rd_data       (rd_data),
    .alphabet_low  (alphabet_low),
    .alphabet_high (alphabet_high),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digit_char    (digit_char),
    .digit_total   (digit_total),
    .last          (last)
  );

endmodule
